// ----- hdl/asfc_pkg.sv -----
// package with types, constants and the crc byte update for the syncframe framer
package asfc_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hAC;
  localparam logic [6:0]  SYNC_SECOND_HI  = 7'h20;
  localparam logic [15:0] CRC_INIT        = 16'h0000;
  localparam logic [15:0] ESCAPE_SIZE     = 16'hFFFF;
  localparam logic [24:0] BASE_HEADER_ADD = 25'd4;
  localparam logic [24:0] EXT_HEADER_ADD  = 25'd7;
  localparam logic [24:0] CRC_WORD_BYTES  = 25'd2;
  localparam logic [3:0]  GOOD_MAX        = 4'd15;

  localparam logic [3:0]  FRAMES_TO_LOCK_RST = 4'd4;
  localparam logic [15:0] CRC_POLY_RST       = 16'h8005;

  localparam int          CFG_IDX_W  = 1;
  localparam int          CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_TO_LOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY       = 1'b1;

  localparam int          QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_SIZE16 = 3'd2,
    PH_SIZE24 = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic {
    EV_LOSE  = 1'b0,
    EV_FRAME = 1'b1
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [24:0] length;
    logic        has_crc;
    logic        crc_ok;
  } event_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- hdl/asfc_in_if.sv -----
// byte request channel
interface asfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ----- hdl/asfc_out_if.sv -----
// frame report channel
interface asfc_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] frame_length;
  logic        has_crc;
  logic        crc_ok;
  logic        locked;

  modport source (output valid, output frame_length, output has_crc, output crc_ok,
                  output locked, input ready);
  modport sink (input valid, input frame_length, input has_crc, input crc_ok,
                input locked, output ready);
endinterface

// ----- hdl/asfc_cfg_if.sv -----
// configuration write channel
interface asfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [asfc_pkg::CFG_IDX_W-1:0]  index;
  logic [asfc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/asfc_front.sv -----
// front end: sync hunt, header parse, crc and frame delineation, emits events
module asfc_front (
  input  logic              clk,
  input  logic              rst_n,
  asfc_in_if.sink           in_ch,
  input  logic [15:0]       crc_poly,
  input  logic              q_full,
  output logic              ev_push,
  output asfc_pkg::event_t  ev
);

  asfc_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] size_r, size_nxt;
  logic [24:0] len_r, len_nxt;
  logic [24:0] left_r, left_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        present_r, present_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_fed;
  logic [15:0] size16;
  logic [23:0] size24;
  logic [24:0] extra;
  logic [24:0] hdr_left;
  logic [24:0] hdr_len;
  logic [24:0] left_dec;
  logic        ok_fed;
  logic        sync2_ok;
  logic        hunt_like;
  logic        hdr_done;
  logic        frame_now;
  logic        lose_now;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  assign crc_fed  = asfc_pkg::crc_byte(crc_r, b, crc_poly);
  assign size16   = {size_r[7:0], b};
  assign size24   = {size_r[15:0], b};
  assign extra    = present_r ? asfc_pkg::CRC_WORD_BYTES : 25'd0;
  assign hdr_left = (phase_r == asfc_pkg::PH_SIZE24) ? ({1'b0, size24} + extra)
                                                     : ({9'd0, size16} + extra);
  assign hdr_len  = hdr_left + ((phase_r == asfc_pkg::PH_SIZE24) ? asfc_pkg::EXT_HEADER_ADD
                                                                : asfc_pkg::BASE_HEADER_ADD);
  assign left_dec = (left_r == 25'd0) ? 25'd0 : left_r - 25'd1;
  assign ok_fed   = !present_r || (crc_fed == asfc_pkg::CRC_INIT);
  assign sync2_ok = (b[7:1] == asfc_pkg::SYNC_SECOND_HI);

  assign hunt_like = (phase_r != asfc_pkg::PH_SYNC2) && (phase_r != asfc_pkg::PH_SIZE16) &&
                     (phase_r != asfc_pkg::PH_SIZE24) && (phase_r != asfc_pkg::PH_BODY);

  assign hdr_done = ((phase_r == asfc_pkg::PH_SIZE16) && (idx_r == 2'd1) &&
                     (size16 != asfc_pkg::ESCAPE_SIZE)) ||
                    ((phase_r == asfc_pkg::PH_SIZE24) && (idx_r == 2'd2));

  assign frame_now = accept && ((hdr_done && (hdr_left == 25'd0)) ||
                                ((phase_r == asfc_pkg::PH_BODY) && (left_dec == 25'd0)));

  assign lose_now = accept && (((phase_r == asfc_pkg::PH_SYNC2) && !sync2_ok) ||
                               (hunt_like && (b != asfc_pkg::SYNC_FIRST)));

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    size_nxt    = size_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    present_nxt = present_r;
    if (accept) begin
      unique case (phase_r)
        asfc_pkg::PH_SYNC2: begin
          if (sync2_ok) begin
            present_nxt = b[0];
            crc_nxt     = asfc_pkg::CRC_INIT;
            idx_nxt     = 2'd0;
            size_nxt    = 24'd0;
            phase_nxt   = asfc_pkg::PH_SIZE16;
          end else begin
            phase_nxt = (b == asfc_pkg::SYNC_FIRST) ? asfc_pkg::PH_SYNC2 : asfc_pkg::PH_HUNT;
          end
        end
        asfc_pkg::PH_SIZE16: begin
          crc_nxt  = crc_fed;
          size_nxt = {8'd0, size16};
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == 2'd1) begin
            idx_nxt = 2'd0;
            if (size16 == asfc_pkg::ESCAPE_SIZE) begin
              size_nxt  = 24'd0;
              phase_nxt = asfc_pkg::PH_SIZE24;
            end else begin
              left_nxt  = hdr_left;
              len_nxt   = hdr_len;
              phase_nxt = (hdr_left == 25'd0) ? asfc_pkg::PH_HUNT : asfc_pkg::PH_BODY;
            end
          end
        end
        asfc_pkg::PH_SIZE24: begin
          crc_nxt  = crc_fed;
          size_nxt = size24;
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            left_nxt  = hdr_left;
            len_nxt   = hdr_len;
            phase_nxt = (hdr_left == 25'd0) ? asfc_pkg::PH_HUNT : asfc_pkg::PH_BODY;
          end
        end
        asfc_pkg::PH_BODY: begin
          crc_nxt  = crc_fed;
          left_nxt = left_dec;
          if (left_dec == 25'd0) begin
            phase_nxt = asfc_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_nxt = (b == asfc_pkg::SYNC_FIRST) ? asfc_pkg::PH_SYNC2 : asfc_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // event outputs
  always_comb begin
    ev_push    = frame_now || lose_now;
    ev.kind    = frame_now ? asfc_pkg::EV_FRAME : asfc_pkg::EV_LOSE;
    ev.length  = (phase_r == asfc_pkg::PH_BODY) ? len_r : hdr_len;
    ev.has_crc = present_r;
    ev.crc_ok  = ok_fed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= asfc_pkg::PH_HUNT;
      size_r    <= '0;
      len_r     <= '0;
      left_r    <= '0;
      idx_r     <= '0;
      crc_r     <= asfc_pkg::CRC_INIT;
      present_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      size_r    <= size_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      present_r <= present_nxt;
    end
  end

endmodule

// ----- hdl/asfc_queue.sv -----
// short event queue between front and back
module asfc_queue #(
  parameter int DEPTH = asfc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  asfc_pkg::event_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output asfc_pkg::event_t head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  asfc_pkg::event_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/asfc_back.sv -----
// back end: good frame counting, lock tracking and the result register
module asfc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [3:0]       frames_to_lock,
  input  logic             ev_valid,
  input  asfc_pkg::event_t ev,
  output logic             ev_pop,
  asfc_out_if.source       out_ch
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic        lock_r, lock_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [24:0] len_r;
  logic        has_crc_r;
  logic        crc_ok_r;
  logic        locked_r;

  logic        slot_free;
  logic        is_frame;
  logic        take_frame;
  logic [3:0]  cnt_inc;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign is_frame   = (ev.kind == asfc_pkg::EV_FRAME);
  assign ev_pop     = ev_valid && (!is_frame || slot_free);
  assign take_frame = ev_pop && is_frame;
  assign cnt_inc    = (cnt_r == asfc_pkg::GOOD_MAX) ? cnt_r : cnt_r + 4'd1;

  always_comb begin
    cnt_nxt  = cnt_r;
    lock_nxt = lock_r;
    if (ev_pop) begin
      if (is_frame && ev.crc_ok) begin
        cnt_nxt  = cnt_inc;
        lock_nxt = lock_r || (cnt_inc >= frames_to_lock);
      end else begin
        cnt_nxt  = 4'd0;
        lock_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take_frame) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lock_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      lock_r      <= lock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_frame) begin
      len_r     <= ev.length;
      has_crc_r <= ev.has_crc;
      crc_ok_r  <= ev.crc_ok;
      locked_r  <= lock_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_length = len_r;
  assign out_ch.has_crc      = has_crc_r;
  assign out_ch.crc_ok       = crc_ok_r;
  assign out_ch.locked       = locked_r;

endmodule

// ----- hdl/audio_syncframe_framer_crc.sv -----
// top level of the syncframe framer with crc-16 check
// usage:
//   in_ch takes one stream byte per request, one per cycle when in_ch.ready is high
//   out_ch gives one report per frame end: length, crc presence, crc verdict, lock
//   cfg_ch writes frames_to_lock (index 0) or crc_polynomial (index 1); always ready,
//   to be used only while no byte is in flight
// throughput: one byte per cycle while the event queue is not full; the front parser and
//   crc update finish a byte in the cycle it is accepted
// path: a frame report passes from the front through the event queue and the result
//   register to out_ch
// stall: while out_ch.ready is low the result register holds, frame events wait in
//   the queue of QUEUE_DEPTH entries and in_ch.ready falls once the queue is full;
//   sync loss events drain without waiting for the receiver
// reset: synchronous rst_n low puts the parser in sync hunt, clears lock and the
//   good frame count, empties the queue and loads frames_to_lock 4 and polynomial 0x8005
module audio_syncframe_framer_crc #(
  parameter int QUEUE_DEPTH = asfc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  asfc_in_if.sink    in_ch,
  asfc_out_if.source out_ch,
  asfc_cfg_if.sink   cfg_ch
);

  logic [3:0]       ftl_r, ftl_nxt;
  logic [15:0]      poly_r, poly_nxt;

  logic             q_full;
  logic             ev_push;
  asfc_pkg::event_t ev_in;
  logic             ev_pop;
  logic             head_valid;
  asfc_pkg::event_t head_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    ftl_nxt  = ftl_r;
    poly_nxt = poly_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        asfc_pkg::CFG_FRAMES_TO_LOCK: ftl_nxt  = cfg_ch.data[3:0];
        asfc_pkg::CFG_CRC_POLY:       poly_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ftl_r  <= asfc_pkg::FRAMES_TO_LOCK_RST;
      poly_r <= asfc_pkg::CRC_POLY_RST;
    end else begin
      ftl_r  <= ftl_nxt;
      poly_r <= poly_nxt;
    end
  end

  asfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .crc_poly (poly_r),
    .q_full   (q_full),
    .ev_push  (ev_push),
    .ev       (ev_in)
  );

  asfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_push),
    .push_data  (ev_in),
    .full       (q_full),
    .pop        (ev_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  asfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .frames_to_lock (ftl_r),
    .ev_valid       (head_valid),
    .ev             (head_data),
    .ev_pop         (ev_pop),
    .out_ch         (out_ch)
  );

endmodule

// ----- tb/tb.sv -----
// testbench for the syncframe framer: frame streams, crc checks and lock reports against a predictor
`timescale 1ns / 1ps

module tb;
  import asfc_pkg::*;

  localparam int PHASES         = 5;
  localparam int PHASE_BYTES    = 260;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [24:0] length;
    logic        has_crc;
    logic        crc_ok;
    logic        locked;
  } frame_report_t;

  class frame_report_board;
    phase_t        phase;
    logic [24:0]   size_acc;
    logic [24:0]   left;
    logic [2:0]    hdr_idx;
    logic [15:0]   crc;
    logic          crc_on;
    logic [3:0]    good_cnt;
    logic          lock;
    logic [3:0]    lock_after;
    logic [15:0]   poly;
    frame_report_t reports_due[$];
    int            errors;

    function new();
      phase      = PH_HUNT;
      size_acc   = '0;
      left       = '0;
      hdr_idx    = '0;
      crc        = CRC_INIT;
      crc_on     = 1'b0;
      good_cnt   = '0;
      lock       = 1'b0;
      lock_after = FRAMES_TO_LOCK_RST;
      poly       = CRC_POLY_RST;
      errors     = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b, logic [15:0] p);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        if (r[15]) r = {r[14:0], 1'b0} ^ p;
        else r = {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_FRAMES_TO_LOCK) lock_after = val[3:0];
      else if (idx == CFG_CRC_POLY) poly = val;
    endfunction

    function void drop_lock();
      good_cnt = '0;
      lock     = 1'b0;
    endfunction

    function void close_frame();
      frame_report_t r;
      logic          ok;
      ok = !crc_on || (crc == CRC_INIT);
      if (ok) begin
        if (good_cnt < GOOD_MAX) good_cnt = good_cnt + 1'b1;
        if (good_cnt >= lock_after) lock = 1'b1;
      end else begin
        drop_lock();
      end
      r.length  = size_acc;
      r.has_crc = crc_on;
      r.crc_ok  = ok;
      r.locked  = lock;
      reports_due.push_back(r);
      phase = PH_HUNT;
    endfunction

    function void finish_header(logic [24:0] size, logic [24:0] add);
      logic [24:0] extra;
      extra    = crc_on ? CRC_WORD_BYTES : 25'd0;
      left     = size + extra;
      size_acc = size + add + extra;
      phase    = PH_BODY;
      if (left == 0) close_frame();
    endfunction

    // one accepted byte through the parser
    function void take_byte(logic [7:0] b);
      case (phase)
        PH_SYNC2: begin
          if (b[7:1] == SYNC_SECOND_HI) begin
            crc_on   = b[0];
            crc      = CRC_INIT;
            hdr_idx  = '0;
            size_acc = '0;
            phase    = PH_SIZE16;
          end else begin
            drop_lock();
            phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
          end
        end
        PH_SIZE16: begin
          crc      = crc_step(crc, b, poly);
          size_acc = {9'd0, size_acc[7:0], b};
          hdr_idx  = hdr_idx + 1'b1;
          if (hdr_idx >= 3'd2) begin
            hdr_idx = '0;
            if (size_acc[15:0] == ESCAPE_SIZE) begin
              size_acc = '0;
              phase    = PH_SIZE24;
            end else begin
              finish_header(size_acc, BASE_HEADER_ADD);
            end
          end
        end
        PH_SIZE24: begin
          crc      = crc_step(crc, b, poly);
          size_acc = {1'b0, size_acc[15:0], b};
          hdr_idx  = hdr_idx + 1'b1;
          if (hdr_idx >= 3'd3) begin
            hdr_idx = '0;
            finish_header(size_acc, EXT_HEADER_ADD);
          end
        end
        PH_BODY: begin
          crc = crc_step(crc, b, poly);
          if (left != 0) left = left - 1'b1;
          if (left == 0) close_frame();
        end
        default: begin
          if (b == SYNC_FIRST) begin
            phase = PH_SYNC2;
          end else begin
            drop_lock();
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t exp;
      if (reports_due.size() == 0) begin
        $error("frame report with none expected: length %0d", got.length);
        errors++;
        return;
      end
      exp = reports_due.pop_front();
      if (got.length !== exp.length) begin
        $error("frame_length: expected %0d, got %0d", exp.length, got.length);
        errors++;
      end
      if (got.has_crc !== exp.has_crc) begin
        $error("has_crc: expected %0b, got %0b", exp.has_crc, got.has_crc);
        errors++;
      end
      if (got.crc_ok !== exp.crc_ok) begin
        $error("crc_ok: expected %0b, got %0b", exp.crc_ok, got.crc_ok);
        errors++;
      end
      if (got.locked !== exp.locked) begin
        $error("locked: expected %0b, got %0b", exp.locked, got.locked);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  asfc_in_if  in_bus ();
  asfc_out_if out_bus ();
  asfc_cfg_if cfg_bus ();

  audio_syncframe_framer_crc dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  frame_report_board reports;
  logic [7:0]        stream_q[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  bit                hold_req = 1'b0;
  int                quiet_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(5, 20);
    return $urandom_range(21, 60);
  endfunction

  // noise never holds a second sync byte, so the parser cannot lock onto a random header
  function automatic void add_noise(int unsigned n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b[7:1] == SYNC_SECOND_HI) b[7] = 1'b1;
      stream_q.push_back(b);
    end
  endfunction

  function automatic void add_frame(bit with_crc, bit ext, int unsigned size, bit corrupt);
    logic [23:0] sz;
    logic [15:0] crc;
    int unsigned hdr_start;
    int unsigned body_start;
    int unsigned pos;
    sz  = 24'(size);
    crc = CRC_INIT;
    stream_q.push_back(SYNC_FIRST);
    stream_q.push_back({SYNC_SECOND_HI, with_crc});
    hdr_start = stream_q.size();
    if (ext) begin
      stream_q.push_back(ESCAPE_SIZE[15:8]);
      stream_q.push_back(ESCAPE_SIZE[7:0]);
      stream_q.push_back(sz[23:16]);
    end
    stream_q.push_back(sz[15:8]);
    stream_q.push_back(sz[7:0]);
    body_start = stream_q.size();
    for (int i = 0; i < size; i++) stream_q.push_back(8'($urandom_range(0, 255)));
    for (int i = hdr_start; i < stream_q.size(); i++)
      crc = frame_report_board::crc_step(crc, stream_q[i], reports.poly);
    if (with_crc) begin
      stream_q.push_back(crc[15:8]);
      stream_q.push_back(crc[7:0]);
    end
    if (corrupt && stream_q.size() > body_start) begin
      pos = $urandom_range(body_start, stream_q.size() - 1);
      stream_q[pos] = stream_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  function automatic void build_random(int unsigned budget);
    int unsigned pick;
    while (stream_q.size() < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        add_frame(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, pick_size(), 1'b0);
      end else if (pick < 86) begin
        add_frame(1'b1, $urandom_range(0, 4) == 0, pick_size(), 1'b1);
      end else if (pick < 93) begin
        add_noise($urandom_range(1, 5));
      end else begin
        stream_q.push_back(SYNC_FIRST);
        add_noise(1);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    reports.take_byte(b);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    reports.set_register(idx, val);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (reports.reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // report side
  initial begin
    int            hold_left;
    frame_report_t got;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.length  = out_bus.frame_length;
        got.has_crc = out_bus.has_crc;
        got.crc_ok  = out_bus.crc_ok;
        got.locked  = out_bus.locked;
        reports.check_report(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned             send_tab [PHASES];
    int unsigned             recv_tab [PHASES];
    logic [CFG_DATA_W-1:0]   lock_tab [PHASES];
    logic [CFG_DATA_W-1:0]   poly_tab [PHASES];
    send_tab = '{0, 88, 0, 23, 0};
    recv_tab = '{0, 0, 88, 23, 0};
    lock_tab = '{16'hFFF0, 16'h000F, 16'h0001, 16'h0004, 16'h0000};
    poly_tab = '{16'h1021, 16'hFFFF, 16'h0000, 16'h8005, 16'h0000};
    lock_tab[4] = CFG_DATA_W'($urandom_range(0, 65535));
    poly_tab[4] = CFG_DATA_W'($urandom_range(0, 65535));

    reports           = new();
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    add_frame(1'b0, 1'b0, 0, 1'b0);
    add_frame(1'b1, 1'b0, 0, 1'b0);
    add_frame(1'b0, 1'b1, 0, 1'b0);
    add_frame(1'b1, 1'b0, 1, 1'b0);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(SYNC_FIRST);
    stream_q.push_back(8'h42);
    stream_q.push_back(SYNC_FIRST);
    add_frame(1'b0, 1'b0, 1, 1'b0);
    add_frame(1'b1, 1'b0, 3, 1'b1);
    send_stream();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_FRAMES_TO_LOCK, lock_tab[p]);
      write_reg(CFG_CRC_POLY, poly_tab[p]);
      send_idle_pct  = send_tab[p];
      recv_stall_pct = recv_tab[p];
      build_random(PHASE_BYTES);
      if (p == 0) begin
        hold_req = 1'b1;
        add_frame(1'b0, 1'b0, 48, 1'b0);
        add_frame(1'b1, 1'b1, 36, 1'b0);
      end
      send_stream();
      settle();
    end

    if (reports.reports_due.size() != 0) begin
      $error("%0d frame reports never arrived", reports.reports_due.size());
      reports.errors++;
    end
    if (reports.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
